### src/pbts_pkg.sv
// Shared types and constants for the bitmap priority task scheduler.
// Used by the scheduler cells, the top level and the port checker.
`timescale 1ns / 1ps

package pbts_pkg;

   localparam int NUM_PRIORITIES_DEF = 32;
   localparam int PRIO_W             = 5;
   localparam int OP_W               = 2;
   localparam int TICKS_W            = 16;
   localparam int TICK_W             = 32;
   localparam int MASK_W             = 32;
   localparam int REQ_DATA_W         = 24;
   localparam int RSP_DATA_W         = 72;

   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_DELAY  = 2'd1;
   localparam logic [OP_W-1:0] OP_CREATE = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   // Command broadcast to every cell at the cycle an item is accepted.
   typedef struct packed {
      logic                apply;
      logic [OP_W-1:0]     op;
      logic [PRIO_W-1:0]   prio;       // target priority for create or delay
      logic [TICK_W-1:0]   tick_next;  // counter value after a tick
      logic                wrap;       // tick wraps the counter to zero
      logic [TICK_W-1:0]   wake;       // wake time of a delay
      logic                wake_late;  // wake time lies past the next wrap
   } cmd_type;

   // Highest ready priority seen so far along the chain.
   typedef struct packed {
      logic              found;
      logic [PRIO_W-1:0] prio;
   } carry_type;

endpackage

### src/pbts_cell.sv
// One scheduler cell: the wake times, ready bit and delayed bit of a single
// priority, plus one registered stage of the highest-ready search chain.
// Depends on pbts_pkg.
`timescale 1ns / 1ps

module pbts_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  pbts_pkg::cmd_type   cmd,
   input  pbts_pkg::carry_type carry_in,
   output pbts_pkg::carry_type carry_out,
   output logic                ready_o,
   output logic                delayed_o
);

   logic                        ready_ff, ready_in;
   logic                        delayed_ff, delayed_in;
   logic [pbts_pkg::TICK_W-1:0] now_ff, now_in;
   logic [pbts_pkg::TICK_W-1:0] after_ff, after_in;
   pbts_pkg::carry_type         carry_ff, carry_in_next;

   logic                        sel;
   logic [pbts_pkg::TICK_W-1:0] now_eff;
   logic [pbts_pkg::TICK_W-1:0] after_eff;
   logic                        due;

   assign sel       = (cmd.prio == pbts_pkg::PRIO_W'(CELL_INDEX));
   // On a counter wrap the two tables trade places before the compare.
   assign now_eff   = cmd.wrap ? after_ff : now_ff;
   assign after_eff = cmd.wrap ? now_ff : after_ff;
   assign due       = (now_eff != '0) && (cmd.tick_next >= now_eff);

   always_comb begin
      ready_in   = ready_ff;
      delayed_in = delayed_ff;
      now_in     = now_ff;
      after_in   = after_ff;
      if (cmd.apply) begin
         unique case (cmd.op)
            pbts_pkg::OP_TICK: begin
               after_in = after_eff;
               if (due) begin
                  now_in     = '0;
                  delayed_in = 1'b0;
                  ready_in   = 1'b1;
               end else begin
                  now_in = now_eff;
               end
            end
            pbts_pkg::OP_DELAY: begin
               if (sel) begin
                  if (cmd.wake_late) begin
                     after_in = cmd.wake;
                  end else begin
                     now_in = cmd.wake;
                  end
                  delayed_in = 1'b1;
                  ready_in   = 1'b0;
               end
            end
            pbts_pkg::OP_CREATE: begin
               if (sel) begin
                  ready_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // A higher cell overrides whatever the lower cells found.
   always_comb begin
      if (ready_ff) begin
         carry_in_next.found = 1'b1;
         carry_in_next.prio  = pbts_pkg::PRIO_W'(CELL_INDEX);
      end else begin
         carry_in_next = carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff   <= 1'b0;
         delayed_ff <= 1'b0;
         now_ff     <= '0;
         after_ff   <= '0;
         carry_ff   <= '0;
      end else begin
         ready_ff   <= ready_in;
         delayed_ff <= delayed_in;
         now_ff     <= now_in;
         after_ff   <= after_in;
         carry_ff   <= carry_in_next;
      end
   end

   assign carry_out = carry_ff;
   assign ready_o   = ready_ff;
   assign delayed_o = delayed_ff;

endmodule

### src/priority_bitmap_task_scheduler.sv
// Top level of the bitmap priority task scheduler: tick counter, sequencer,
// output register and the row of scheduler cells.
// Depends on pbts_pkg and pbts_cell.
`timescale 1ns / 1ps
//
// Usage
//   req channel: one item per event. req_tuser carries the opcode (tick, delay
//   the running task, create a task); req_tdata carries the priority of a
//   created task and the tick count of a delay.
//   rsp channel: exactly one item per request, holding the running priority,
//   the none-ready flag and the ready and delayed masks after the event.
// Processing
//   A tick or a delay finds the highest ready priority with a registered chain
//   through the cells, one cell per cycle, and raises rsp_tvalid once the last
//   chain stage has settled. A create or an unused opcode skips the chain and is
//   loaded into the output register once it is free. The next request is taken
//   the cycle after the response has been loaded into the output register.
// Reset
//   Synchronous reset clears the counter, both masks, all wake times and the
//   running priority, and drops rsp_tvalid.
// Stalls
//   While rsp_tready is low the response holds; one further request may be
//   accepted and processed, and its result waits until the output frees up.

module priority_bitmap_task_scheduler #(
   parameter int NUM_PRIORITIES = pbts_pkg::NUM_PRIORITIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [4:0] priority_req, [20:5] delay_ticks, [23:21] zero
   input  logic [pbts_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [pbts_pkg::OP_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [4:0] current_priority, [5] none_ready, [37:6] ready_mask,
   // [69:38] delayed_mask, [71:70] zero
   output logic [pbts_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [pbts_pkg::TICK_W-1:0]     tick_ff, tick_in;
   logic [pbts_pkg::PRIO_W-1:0]     running_ff, running_in;
   logic                            pick_ff, pick_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pbts_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                            accept;
   logic                            load;
   logic [pbts_pkg::OP_W-1:0]       op;
   logic [pbts_pkg::PRIO_W-1:0]     prio_req;
   logic [pbts_pkg::TICKS_W-1:0]    delay_ticks;
   logic                            create_ok;
   logic [pbts_pkg::TICK_W:0]       wake_sum;
   pbts_pkg::cmd_type               cmd;
   pbts_pkg::carry_type             carry [NUM_PRIORITIES+1];
   logic [NUM_PRIORITIES-1:0]       ready_vec;
   logic [NUM_PRIORITIES-1:0]       delayed_vec;
   logic [pbts_pkg::MASK_W-1:0]     ready_mask;
   logic [pbts_pkg::MASK_W-1:0]     delayed_mask;

   assign op          = req_tuser;
   assign prio_req    = req_tdata[4:0];
   assign delay_ticks = req_tdata[20:5];
   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign create_ok   = (int'(prio_req) < NUM_PRIORITIES);
   assign wake_sum    = {1'b0, tick_ff} + (pbts_pkg::TICK_W + 1)'(delay_ticks);

   always_comb begin
      cmd.apply     = accept && !((op == pbts_pkg::OP_CREATE) && !create_ok);
      cmd.op        = op;
      cmd.prio      = (op == pbts_pkg::OP_CREATE) ? prio_req : running_ff;
      cmd.tick_next = tick_ff + 1'b1;
      cmd.wrap      = (tick_ff == '1);
      cmd.wake      = wake_sum[pbts_pkg::TICK_W-1:0];
      // A carry out of the add means the wake time is below the counter.
      cmd.wake_late = wake_sum[pbts_pkg::TICK_W];
   end

   assign carry[0] = '0;

   for (genvar i = 0; i < NUM_PRIORITIES; i++) begin : g_cell
      pbts_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .carry_in (carry[i]),
         .carry_out(carry[i+1]),
         .ready_o  (ready_vec[i]),
         .delayed_o(delayed_vec[i])
      );
   end

   assign ready_mask   = pbts_pkg::MASK_W'(ready_vec);
   assign delayed_mask = pbts_pkg::MASK_W'(delayed_vec);
   assign load         = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      tick_in    = tick_ff;
      running_in = running_ff;
      pick_in    = pick_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               unique case (op)
                  pbts_pkg::OP_TICK: begin
                     tick_in  = cmd.tick_next;
                     pick_in  = 1'b1;
                     state_in = ST_SCAN;
                  end
                  pbts_pkg::OP_DELAY: begin
                     pick_in  = 1'b1;
                     state_in = ST_SCAN;
                  end
                  pbts_pkg::OP_CREATE: begin
                     if (create_ok) begin
                        running_in = prio_req;
                     end
                     pick_in  = 1'b0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     pick_in  = 1'b0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // The last chain stage is settled once every cell has been passed.
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_PRIORITIES - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               if (pick_ff && carry[NUM_PRIORITIES].found) begin
                  running_in = carry[NUM_PRIORITIES].prio;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, delayed_mask, ready_mask, ~|ready_vec, running_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tick_ff      <= '0;
         running_ff   <= '0;
         pick_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tick_ff      <= tick_in;
         running_ff   <= running_in;
         pick_ff      <= pick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/pbts_checker.sv
// Port-level checks for the bitmap priority task scheduler, bound to the top.
// Depends on pbts_pkg and priority_bitmap_task_scheduler.
`timescale 1ns / 1ps

module pbts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pbts_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The none-ready flag agrees with the ready mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5] == (rsp_tdata[37:6] == '0)))
      else $error("none_ready disagrees with ready mask");

   // When something is ready, the running priority is one of the ready tasks.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[5] |-> ((rsp_tdata[37:6] >> rsp_tdata[4:0]) & 32'd1) != '0)
      else $error("running priority is not ready");

   // Requests are handled one at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

endmodule

bind priority_bitmap_task_scheduler pbts_checker u_pbts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

### bench/testbench.sv
// Self-checking bench for the bitmap priority task scheduler: directed events, random
// events and task sequences, with random stalls on both stream channels.
// Depends on pbts_pkg and the priority_bitmap_task_scheduler top level.
`timescale 1ns / 1ps

module testbench;
   import pbts_pkg::*;

   localparam int NPRIO       = NUM_PRIORITIES_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 2 * NPRIO + 8;

   typedef struct packed {
      logic [PRIO_W-1:0] current_priority;
      logic              none_ready;
      logic [MASK_W-1:0] ready_mask;
      logic [MASK_W-1:0] delayed_mask;
   } sched_view_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [4:0] priority_req, [20:5] delay_ticks
   logic [OP_W-1:0]       req_tuser;   // [1:0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [4:0] current_priority, [5] none_ready, [37:6] ready_mask, [69:38] delayed_mask
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Scheduler state mirrored by the bench.
   logic [TICK_W-1:0] model_ticks;
   logic [MASK_W-1:0] model_ready;
   logic [MASK_W-1:0] model_delayed;
   logic [TICK_W-1:0] wake_this_epoch [NPRIO];
   logic [TICK_W-1:0] wake_next_epoch [NPRIO];
   logic [PRIO_W-1:0] model_running;

   sched_view_type pending_views [$];

   int  error_count;
   int  cycle_count;
   int  items_sent;
   bit  send_idle;
   bit  recv_idle;
   int  stall_left;

   priority_bitmap_task_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The running task becomes the highest ready priority; with nothing ready it stays.
   function automatic void select_running();
      for (int p = NPRIO - 1; p >= 0; p--) begin
         if (model_ready[p]) begin
            model_running = PRIO_W'(p);
            return;
         end
      end
   endfunction

   function automatic sched_view_type apply_event(logic [OP_W-1:0] op, logic [PRIO_W-1:0] prio,
                                                  logic [TICKS_W-1:0] ticks);
      logic [TICK_W-1:0] wake;
      logic [TICK_W-1:0] held;
      sched_view_type    view;
      case (op)
         OP_TICK: begin
            model_ticks = model_ticks + 1;
            // On a counter wrap the late table becomes the current one.
            if (model_ticks == '0) begin
               for (int i = 0; i < NPRIO; i++) begin
                  held               = wake_this_epoch[i];
                  wake_this_epoch[i] = wake_next_epoch[i];
                  wake_next_epoch[i] = held;
               end
            end
            for (int i = 0; i < NPRIO; i++) begin
               if (wake_this_epoch[i] != '0 && model_ticks >= wake_this_epoch[i]) begin
                  wake_this_epoch[i] = '0;
                  model_delayed[i]   = 1'b0;
                  model_ready[i]     = 1'b1;
               end
            end
            select_running();
         end
         OP_DELAY: begin
            wake = model_ticks + TICK_W'(ticks);
            if (wake < model_ticks)
               wake_next_epoch[model_running] = wake;
            else
               wake_this_epoch[model_running] = wake;
            model_delayed[model_running] = 1'b1;
            model_ready[model_running]   = 1'b0;
            select_running();
         end
         OP_CREATE: begin
            if (int'(prio) < NPRIO) begin
               model_running     = prio;
               model_ready[prio] = 1'b1;
            end
         end
         default: begin
         end
      endcase
      view.current_priority = model_running;
      view.none_ready       = (model_ready == '0);
      view.ready_mask       = model_ready;
      view.delayed_mask     = model_delayed;
      return view;
   endfunction

   // Drives one event item from the falling edge and records its expected report.
   task automatic send_item(logic [OP_W-1:0] op, logic [PRIO_W-1:0] prio,
                            logic [TICKS_W-1:0] ticks);
      @(negedge clock);
      if (send_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, ticks, prio};
      do @(posedge clock); while (!req_tready);
      pending_views.push_back(apply_event(op, prio, ticks));
      items_sent++;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!reset && recv_idle && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sched_view_type want;
      sched_view_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.current_priority = rsp_tdata[4:0];
         got.none_ready       = rsp_tdata[5];
         got.ready_mask       = rsp_tdata[37:6];
         got.delayed_mask     = rsp_tdata[69:38];
         if (pending_views.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("[%0d] unexpected report: prio=%0d none=%0b ready=%h delayed=%h",
                        cycle_count, got.current_priority, got.none_ready,
                        got.ready_mask, got.delayed_mask);
         end else begin
            want = pending_views.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10)
                  $display({"[%0d] mismatch: expected prio=%0d none=%0b ready=%h delayed=%h,",
                            " got prio=%0d none=%0b ready=%h delayed=%h"},
                           cycle_count, want.current_priority, want.none_ready,
                           want.ready_mask, want.delayed_mask, got.current_priority,
                           got.none_ready, got.ready_mask, got.delayed_mask);
            end
         end
      end
   end

   // Corner cases from a fresh reset, where the tick counter starts at zero.
   task automatic test_directed_cases();
      send_item(OP_NOP, 5'd31, 16'hFFFF);
      // A delay before any create acts on priority zero; at tick zero the wake
      // time comes out as zero, so that task never wakes by itself.
      send_item(OP_DELAY, 5'd0, 16'd0);
      send_item(OP_TICK, 5'd31, 16'hFFFF);
      send_item(OP_TICK, 5'd0, 16'd0);
      send_item(OP_CREATE, 5'd31, 16'd0);
      send_item(OP_CREATE, 5'd0, 16'hFFFF);
      // A delay of zero at a nonzero count wakes at the next tick.
      send_item(OP_DELAY, 5'd0, 16'd0);
      send_item(OP_TICK, 5'd0, 16'd0);
      send_item(OP_DELAY, 5'd0, 16'hFFFF);
      send_item(OP_CREATE, 5'd21, 16'd0);
      send_item(OP_CREATE, 5'd10, 16'd0);
      send_item(OP_DELAY, 5'd0, 16'h5555);
      send_item(OP_DELAY, 5'd0, 16'hAAAA);
      // Delaying the last ready task leaves nothing to run.
      send_item(OP_DELAY, 5'd0, 16'd3);
      send_item(OP_DELAY, 5'd0, 16'd2);
      send_item(OP_TICK, 5'd0, 16'd0);
      send_item(OP_TICK, 5'd0, 16'd0);
      send_item(OP_TICK, 5'd0, 16'd0);
      send_item(OP_NOP, 5'd0, 16'd0);
      send_item(OP_CREATE, 5'd31, 16'd0);
      send_item(OP_DELAY, 5'd0, 16'd1);
      send_item(OP_TICK, 5'd0, 16'd0);
   endtask

   // Unstructured events with random fields over their full ranges.
   task automatic test_random_events(int count);
      for (int n = 0; n < count; n++)
         send_item(OP_W'($urandom_range(0, 3)), PRIO_W'($urandom_range(0, 31)),
                   TICKS_W'($urandom_range(0, 65535)));
   endtask

   // Bursts that create a few tasks and then run them through short delays and
   // ticks, so tasks keep waking and preempting each other. With vary_idle set,
   // the idle pattern on both channels is reshuffled now and then.
   task automatic test_task_sequences(int count, bit vary_idle);
      int                 stop_at;
      int                 roll;
      logic [TICKS_W-1:0] ticks;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if (vary_idle && $urandom_range(0, 2) == 0) begin
            send_idle = 1'($urandom_range(0, 1));
            recv_idle = 1'($urandom_range(0, 1));
         end
         repeat ($urandom_range(1, 4))
            send_item(OP_CREATE, PRIO_W'($urandom_range(0, 31)), TICKS_W'($urandom));
         repeat ($urandom_range(6, 24)) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               send_item(OP_TICK, PRIO_W'($urandom), TICKS_W'($urandom));
            end else if (roll < 85) begin
               roll = $urandom_range(0, 99);
               if (roll < 85)
                  ticks = TICKS_W'($urandom_range(0, 15));
               else if (roll < 95)
                  ticks = TICKS_W'($urandom_range(16, 300));
               else
                  ticks = TICKS_W'($urandom_range(0, 65535));
               send_item(OP_DELAY, PRIO_W'($urandom), ticks);
            end else if (roll < 96) begin
               send_item(OP_CREATE, PRIO_W'($urandom_range(0, 31)), TICKS_W'($urandom));
            end else begin
               send_item(OP_NOP, PRIO_W'($urandom), TICKS_W'($urandom));
            end
         end
      end
   endtask

   // Back-to-back items with the result side always ready.
   task automatic test_steady_stream(int count);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      test_task_sequences(count, 1'b0);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_TICK;
      rsp_tready  = 1'b1;
      error_count = 0;
      cycle_count = 0;
      items_sent  = 0;
      send_idle   = 1'b1;
      recv_idle   = 1'b1;
      stall_left  = 0;

      model_ticks   = '0;
      model_ready   = '0;
      model_delayed = '0;
      model_running = '0;
      for (int i = 0; i < NPRIO; i++) begin
         wake_this_epoch[i] = '0;
         wake_next_epoch[i] = '0;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_events(150);
      test_task_sequences(450, 1'b1);
      test_steady_stream(100);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0 && pending_views.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
